[rtl/prer_pkg.sv]
// ----------------------------------------------------------------------------
// Palindrome radius engine package
// Command and response beat types, opcode and status codes.
// ----------------------------------------------------------------------------
package prer_pkg;

	localparam int OPC_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int POS_IN_W = 10;
	localparam int RADIUS_W = 9;
	localparam int LEN_W    = 9;
	localparam int STAT_W   = 2;

	typedef enum logic [OPC_W-1:0] {
		OP_APPEND = 2'd0,
		OP_FINISH = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t               opcode;
		logic [CHAR_W-1:0]     char_in;
		logic [POS_IN_W-1:0]   position;
	} cmd_t;

	typedef struct packed {
		logic [RADIUS_W-1:0]   radius;
		logic [LEN_W-1:0]      length_now;
		status_t               status;
	} rsp_t;

endpackage

[rtl/palindrome_radius_engine_unit.sv]
// Append, clear and rejected reads: result registered, in the cycle after the beat is taken.
// Accepted reads: result after the registered radius RAM read and the S_READ state.
// Finish: the pace per interleaved position is set by the single char
// RAM read port (two reads per odd-position compare) and the radius RAM port.
// busy is high while a read or finish runs; the result strobe cannot be stalled.
// Reset clears the length and the computed flag; the RAMs are not cleared.
// ----------------------------------------------------------------------------
// Palindrome radius engine
// Loads a byte string, runs Manacher's algorithm over the separator-interleaved
// string with a small sequencer over two RAMs, and serves radius reads.
// ----------------------------------------------------------------------------
module palindrome_radius_engine_unit
	import prer_pkg::*;
#(
	parameter int MAX_LEN = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output rsp_t result
);

	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int CHAR_AW = $clog2(MAX_LEN);
	localparam int SEQ_LEN = 2 * MAX_LEN + 1;
	localparam int IDX_W   = $clog2(SEQ_LEN);
	localparam int POS_W   = IDX_W + 1;
	localparam int RAD_W   = $clog2(MAX_LEN + 2);
	localparam int CMP_W   = ((POS_W > POS_IN_W) ? POS_W : POS_IN_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXPAND,
		S_RDA,
		S_RDB,
		S_STORE,
		S_MREQ,
		S_MCHK
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    count_q;
	logic                ready_q;
	logic [POS_W-1:0]    center_q;
	logic [POS_W-1:0]    last_q;
	logic [RAD_W-1:0]    r_q;
	logic [RAD_W-1:0]    d_q;
	logic [CHAR_W-1:0]   cha_q;
	logic                done_q;
	rsp_t                result_q;

	logic                accept;
	logic                is_full;
	logic                in_range;
	logic [CNT_W-1:0]    cnt_inc;
	logic [POS_W-1:0]    r_ext;
	logic [POS_W-1:0]    d_ext;
	logic [POS_W-1:0]    lo;
	logic [POS_W-1:0]    hi;
	logic [POS_W-1:0]    lo_d;
	logic [POS_W-1:0]    mid;
	logic                can_grow;
	logic [RAD_W-1:0]    rem;
	logic                mr_lt;

	logic                ch_we;
	logic [CHAR_AW-1:0]  ch_waddr;
	logic [CHAR_AW-1:0]  ch_raddr;
	logic [CHAR_W-1:0]   ch_rdata;

	logic                rd_we;
	logic [IDX_W-1:0]    rd_waddr;
	logic [RAD_W-1:0]    rd_wdata;
	logic [IDX_W-1:0]    rd_raddr;
	logic [RAD_W-1:0]    rd_rdata;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign is_full  = (count_q == CNT_W'(MAX_LEN));
	assign cnt_inc  = count_q + 1'b1;
	assign in_range = (CMP_W'(cmd.position) <= CMP_W'({count_q, 1'b0}));
	assign r_ext    = POS_W'(r_q);
	assign d_ext    = POS_W'(d_q);
	assign lo       = center_q - r_ext;
	assign hi       = center_q + r_ext;
	assign lo_d     = center_q - d_ext;
	assign mid      = center_q + d_ext;
	assign can_grow = (r_ext <= center_q) && (hi <= last_q);
	assign rem      = r_q - d_q;
	assign mr_lt    = (rd_rdata < rem);

	always_comb begin
		ch_we    = accept && (cmd.opcode == OP_APPEND) && !is_full;
		ch_waddr = count_q[CHAR_AW-1:0];
		ch_raddr = (state_q == S_RDA) ? hi[CHAR_AW:1] : lo[CHAR_AW:1];
		rd_we    = 1'b0;
		rd_waddr = center_q[IDX_W-1:0];
		rd_wdata = r_q;
		if (state_q == S_STORE) begin
			rd_we = 1'b1;
		end else if (state_q == S_MCHK) begin
			rd_we    = 1'b1;
			rd_waddr = mid[IDX_W-1:0];
			rd_wdata = mr_lt ? rd_rdata : rem;
		end
		rd_raddr = busy ? lo_d[IDX_W-1:0] : IDX_W'(cmd.position);
	end

	prer_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (MAX_LEN)
	) u_char_ram (
		.clk   (clk),
		.we    (ch_we),
		.waddr (ch_waddr),
		.wdata (cmd.char_in),
		.raddr (ch_raddr),
		.rdata (ch_rdata)
	);

	prer_ram #(
		.WIDTH (RAD_W),
		.DEPTH (SEQ_LEN)
	) u_radius_ram (
		.clk   (clk),
		.we    (rd_we),
		.waddr (rd_waddr),
		.wdata (rd_wdata),
		.raddr (rd_raddr),
		.rdata (rd_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ready_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						result_q.radius     <= '0;
						result_q.length_now <= LEN_W'(count_q);
						result_q.status     <= ST_OK;
						case (cmd.opcode)
							OP_APPEND: begin
								done_q <= 1'b1;
								if (is_full) begin
									result_q.status <= ST_FULL;
								end else begin
									count_q             <= cnt_inc;
									ready_q             <= 1'b0;
									result_q.length_now <= LEN_W'(cnt_inc);
								end
							end
							OP_FINISH: begin
								center_q <= '0;
								r_q      <= RAD_W'(1);
								last_q   <= POS_W'({count_q, 1'b0});
								state_q  <= S_EXPAND;
							end
							OP_READ: begin
								if (!ready_q) begin
									done_q          <= 1'b1;
									result_q.status <= ST_NOT_READY;
								end else if (!in_range) begin
									done_q          <= 1'b1;
									result_q.status <= ST_RANGE;
								end else begin
									state_q <= S_READ;
								end
							end
							OP_CLEAR: begin
								done_q              <= 1'b1;
								count_q             <= '0;
								ready_q             <= 1'b0;
								result_q.length_now <= '0;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					done_q              <= 1'b1;
					result_q.radius     <= RADIUS_W'(rd_rdata);
					result_q.length_now <= LEN_W'(count_q);
					result_q.status     <= ST_OK;
					state_q             <= S_IDLE;
				end
				S_EXPAND: begin
					if (!can_grow) begin
						state_q <= S_STORE;
					end else if (!lo[0]) begin
						r_q <= r_q + 1'b1;
					end else begin
						state_q <= S_RDA;
					end
				end
				S_RDA: begin
					cha_q   <= ch_rdata;
					state_q <= S_RDB;
				end
				S_RDB: begin
					if (ch_rdata == cha_q) begin
						r_q     <= r_q + 1'b1;
						state_q <= S_EXPAND;
					end else begin
						state_q <= S_STORE;
					end
				end
				S_STORE: begin
					d_q     <= RAD_W'(1);
					state_q <= S_MREQ;
				end
				S_MREQ: begin
					if (d_q >= r_q) begin
						center_q <= hi;
						r_q      <= RAD_W'(1);
						if (hi > last_q) begin
							done_q              <= 1'b1;
							ready_q             <= 1'b1;
							result_q.radius     <= '0;
							result_q.length_now <= LEN_W'(count_q);
							result_q.status     <= ST_OK;
							state_q             <= S_IDLE;
						end else begin
							state_q <= S_EXPAND;
						end
					end else begin
						state_q <= S_MCHK;
					end
				end
				S_MCHK: begin
					if (mr_lt) begin
						d_q     <= d_q + 1'b1;
						state_q <= S_MREQ;
					end else begin
						center_q <= mid;
						r_q      <= rem;
						state_q  <= S_EXPAND;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while sequencer busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("byte count beyond store depth");

	a_radius_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXPAND || state_q == S_MREQ) |-> (r_q != '0))
		else $error("zero radius in sequencer");

	a_read_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.opcode == OP_READ && !ready_q) |=>
			(done_q && result_q.status == ST_NOT_READY))
		else $error("read before compute not flagged");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.opcode == OP_FINISH) |=> busy)
		else $error("finish beat did not start the sequencer");

endmodule

[rtl/prer_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module prer_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
